// ----- rtl/core/gte_pkg.sv -----
// ----------------------------------------------------------------------------
// gte_pkg
// Shared types, sizes and helpers for the graph traversal engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gte_pkg;

  localparam int MAX_VERTICES = 63;
  localparam int MAX_DEGREE   = 8;

  // Vertex number width, vertex index width, degree width, adjacency address.
  localparam int VW        = $clog2(MAX_VERTICES + 1);
  localparam int IW        = $clog2(MAX_VERTICES);
  localparam int DW        = $clog2(MAX_DEGREE + 1);
  localparam int ADJ_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int AW        = $clog2(ADJ_DEPTH);

  typedef enum logic [1:0] {
    FUNC_EDGE  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_BFS   = 2'd2,
    FUNC_DFS   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_VISIT  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_BPOP,
    ST_BCUR,
    ST_BDEG,
    ST_BEDGE,
    ST_BADJ,
    ST_DTOP,
    ST_DVTX,
    ST_DCHK,
    ST_DADJ
  } state_t;

  // Report events from the sequencer to the result stage.
  typedef struct packed {
    logic          status;
    kind_t         kind;
    logic          visit;
    logic [VW-1:0] vertex;
    logic          flush;
  } rpt_t;

  function automatic logic vertex_ok(input logic [VW-1:0] v);
    return (v != '0) && (v <= VW'(MAX_VERTICES));
  endfunction

  function automatic logic [IW-1:0] vidx(input logic [VW-1:0] v);
    return IW'(v - VW'(1));
  endfunction

  function automatic logic [AW-1:0] adj_addr(input logic [VW-1:0] v,
                                             input logic [DW-1:0] pos);
    return AW'(AW'(vidx(v)) * AW'(MAX_DEGREE) + AW'(pos));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gte_ctrl.sv -----
// ----------------------------------------------------------------------------
// gte_ctrl
// Sequencer for edge loads, graph clears and breadth- or depth-first walks,
// owning the adjacency, degree, work list and edge position memories.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  gte_pkg::func_t        func,
  input  logic [gte_pkg::VW-1:0] source_vertex,
  input  logic [gte_pkg::VW-1:0] target_vertex,
  input  logic [gte_pkg::VW-1:0] start_vertex,
  output logic                  busy,
  output gte_pkg::rpt_t         rpt
);
  import gte_pkg::*;

  state_t state, state_next;
  logic [VW-1:0] head, head_next;
  logic [VW-1:0] tail, tail_next;
  logic [MAX_VERTICES-1:0] visited, visited_next;
  logic [MAX_VERTICES-1:0] deg_valid, deg_valid_next;

  logic [VW-1:0] src, src_next;
  logic [VW-1:0] dst, dst_next;
  logic [VW-1:0] cur, cur_next;
  logic [DW-1:0] deg_cnt, deg_cnt_next;
  logic [DW-1:0] edge_pos, edge_pos_next;

  // Memories with registered reads.
  logic [VW-1:0] adj_mem [ADJ_DEPTH];
  logic [DW-1:0] deg_mem [MAX_VERTICES];
  logic [VW-1:0] work_mem [MAX_VERTICES];
  logic [DW-1:0] nep_mem [MAX_VERTICES];

  logic          adj_we;
  logic [AW-1:0] adj_waddr, adj_raddr;
  logic [VW-1:0] adj_wdata, adj_rd;
  logic          deg_we, deg_clear, deg_vq;
  logic [IW-1:0] deg_waddr, deg_raddr;
  logic [DW-1:0] deg_wdata, deg_rd, deg_eff;
  logic          work_we;
  logic [IW-1:0] work_waddr, work_raddr;
  logic [VW-1:0] work_wdata, work_rd;
  logic          nep_we;
  logic [IW-1:0] nep_waddr, nep_raddr;
  logic [DW-1:0] nep_wdata, nep_rd;

  logic          visit_req, vis_clear;
  logic [VW-1:0] visit_v, visit_tail;

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rd <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_rd <= deg_mem[deg_raddr];
    deg_vq <= deg_valid[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_waddr] <= work_wdata;
    work_rd <= work_mem[work_raddr];
  end

  always_ff @(posedge clk) begin
    if (nep_we) nep_mem[nep_waddr] <= nep_wdata;
    nep_rd <= nep_mem[nep_raddr];
  end

  // A degree entry that has not been written since the last clear reads as zero.
  assign deg_eff = deg_vq ? deg_rd : '0;
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      visited   <= '0;
      deg_valid <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      visited   <= visited_next;
      deg_valid <= deg_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    src      <= src_next;
    dst      <= dst_next;
    cur      <= cur_next;
    deg_cnt  <= deg_cnt_next;
    edge_pos <= edge_pos_next;
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    src_next      = src;
    dst_next      = dst;
    cur_next      = cur;
    deg_cnt_next  = deg_cnt;
    edge_pos_next = edge_pos;

    adj_we     = 1'b0;
    adj_waddr  = adj_addr(src, deg_eff);
    adj_wdata  = dst;
    adj_raddr  = adj_addr(cur, edge_pos);
    deg_we     = 1'b0;
    deg_clear  = 1'b0;
    deg_waddr  = vidx(src);
    deg_wdata  = DW'(deg_eff + DW'(1));
    deg_raddr  = vidx(cur);
    work_we    = 1'b0;
    work_waddr = tail[IW-1:0];
    work_wdata = adj_rd;
    work_raddr = head[IW-1:0];
    nep_we     = 1'b0;
    nep_waddr  = vidx(cur);
    nep_wdata  = '0;
    nep_raddr  = vidx(cur);

    visit_req  = 1'b0;
    visit_v    = adj_rd;
    visit_tail = tail;
    vis_clear  = 1'b0;

    rpt        = '0;
    rpt.kind   = KIND_ACCEPT;

    case (state)
      ST_IDLE: begin
        if (start) begin
          case (func)
            FUNC_EDGE: begin
              if (vertex_ok(source_vertex) && vertex_ok(target_vertex)) begin
                deg_raddr  = vidx(source_vertex);
                src_next   = source_vertex;
                dst_next   = target_vertex;
                state_next = ST_EDGE;
              end else begin
                rpt.status = 1'b1;
                rpt.kind   = KIND_REJECT;
              end
            end
            FUNC_CLEAR: begin
              deg_clear  = 1'b1;
              rpt.status = 1'b1;
              rpt.kind   = KIND_ACCEPT;
            end
            default: begin
              if (!vertex_ok(start_vertex)) begin
                rpt.status = 1'b1;
                rpt.kind   = KIND_REJECT;
              end else begin
                vis_clear  = 1'b1;
                head_next  = '0;
                visit_tail = '0;
                visit_req  = 1'b1;
                visit_v    = start_vertex;
                state_next = (func == FUNC_BFS) ? ST_BPOP : ST_DTOP;
              end
            end
          endcase
        end
      end

      ST_EDGE: begin
        rpt.status = 1'b1;
        if (deg_eff >= DW'(MAX_DEGREE)) begin
          rpt.kind = KIND_REJECT;
        end else begin
          adj_we   = 1'b1;
          deg_we   = 1'b1;
          rpt.kind = KIND_ACCEPT;
        end
        state_next = ST_IDLE;
      end

      ST_BPOP: begin
        if (head < tail) begin
          head_next  = VW'(head + VW'(1));
          state_next = ST_BCUR;
        end else begin
          rpt.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_BCUR: begin
        cur_next   = work_rd;
        deg_raddr  = vidx(work_rd);
        state_next = ST_BDEG;
      end

      ST_BDEG: begin
        deg_cnt_next  = deg_eff;
        edge_pos_next = '0;
        state_next    = ST_BEDGE;
      end

      ST_BEDGE: begin
        if (edge_pos < deg_cnt) begin
          edge_pos_next = DW'(edge_pos + DW'(1));
          state_next    = ST_BADJ;
        end else begin
          state_next = ST_BPOP;
        end
      end

      ST_BADJ: begin
        visit_req  = !visited[vidx(adj_rd)];
        state_next = ST_BEDGE;
      end

      ST_DTOP: begin
        if (tail != '0) begin
          work_raddr = IW'(tail - VW'(1));
          state_next = ST_DVTX;
        end else begin
          rpt.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_DVTX: begin
        cur_next   = work_rd;
        deg_raddr  = vidx(work_rd);
        nep_raddr  = vidx(work_rd);
        state_next = ST_DCHK;
      end

      ST_DCHK: begin
        if (nep_rd < deg_eff) begin
          adj_raddr  = adj_addr(cur, nep_rd);
          nep_we     = 1'b1;
          nep_wdata  = DW'(nep_rd + DW'(1));
          state_next = ST_DADJ;
        end else begin
          tail_next  = VW'(tail - VW'(1));
          state_next = ST_DTOP;
        end
      end

      ST_DADJ: begin
        visit_req  = !visited[vidx(adj_rd)];
        state_next = ST_DTOP;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Marking a vertex visited: reset its edge position, push it and report it.
    if (visit_req) begin
      nep_we     = 1'b1;
      nep_waddr  = vidx(visit_v);
      nep_wdata  = '0;
      rpt.visit  = 1'b1;
      rpt.vertex = visit_v;
      tail_next  = visit_tail;
      if (visit_tail < VW'(MAX_VERTICES)) begin
        work_we    = 1'b1;
        work_waddr = visit_tail[IW-1:0];
        work_wdata = visit_v;
        tail_next  = VW'(visit_tail + VW'(1));
      end
    end

    visited_next = vis_clear ? '0 : visited;
    if (visit_req) visited_next[vidx(visit_v)] = 1'b1;

    deg_valid_next = deg_clear ? '0 : deg_valid;
    if (deg_we) deg_valid_next[deg_waddr] = 1'b1;
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("work list head has passed the tail");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= VW'(MAX_VERTICES))
    else $error("work list overflowed");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    !(rpt.status && (rpt.visit || rpt.flush)) && !(rpt.visit && rpt.flush))
    else $error("more than one report event in a cycle");

  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    rpt.flush |=> !busy)
    else $error("sequencer still busy after the end of a traversal");

endmodule

`default_nettype wire

// ----- rtl/core/gte_result.sv -----
// ----------------------------------------------------------------------------
// gte_result
// Result stage: holds back the latest visited vertex by one report so that
// the final report of a traversal can carry the last flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_result (
  input  logic                   clk,
  input  logic                   rst,
  input  gte_pkg::rpt_t          rpt,
  output logic                   strobe,
  output logic [1:0]             kind,
  output logic [gte_pkg::VW-1:0] vertex,
  output logic                   last
);
  import gte_pkg::*;

  logic          strobe_next, last_next;
  kind_t         kind_next;
  logic [VW-1:0] vertex_next;
  logic          pend_valid, pend_valid_next;
  logic [VW-1:0] pend_vertex, pend_vertex_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe     <= strobe_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind        <= kind_next;
    vertex      <= vertex_next;
    last        <= last_next;
    pend_vertex <= pend_vertex_next;
  end

  always_comb begin
    strobe_next      = 1'b0;
    kind_next        = KIND_VISIT;
    vertex_next      = pend_vertex;
    last_next        = 1'b0;
    pend_valid_next  = pend_valid;
    pend_vertex_next = pend_vertex;
    if (rpt.status) begin
      strobe_next = 1'b1;
      kind_next   = rpt.kind;
      vertex_next = '0;
      last_next   = 1'b1;
    end else if (rpt.visit) begin
      strobe_next      = pend_valid;
      pend_valid_next  = 1'b1;
      pend_vertex_next = rpt.vertex;
    end else if (rpt.flush) begin
      strobe_next     = pend_valid;
      last_next       = 1'b1;
      pend_valid_next = 1'b0;
    end
  end

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !pend_valid)
    else $error("a report is still held after the last beat");

  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> pend_valid && (kind == KIND_VISIT))
    else $error("a non-final beat left no report held");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind != KIND_VISIT) |-> (vertex == '0) && last)
    else $error("status beat with a vertex or without the last flag");

endmodule

`default_nettype wire

// ----- rtl/core/graph_traversal_engine_top.sv -----
// ----------------------------------------------------------------------------
// graph_traversal_engine_top
// Directed graph store with breadth-first and depth-first traversal.
//
//   channel   ports                                         handshake
//   command   func, source_vertex, target_vertex,           start, busy
//             start_vertex
//   result    kind, vertex, last                            strobe
//
// A command beat is taken when start is high and busy is low. A clear, or a
// command rejected for a bad vertex, gives its result in the following
// cycle and leaves busy low; an edge that passes the vertex check holds busy
// in the ST_EDGE state and gives its result from that state through the
// result register. A traversal holds busy while the sequencer steps through
// memories with registered reads; its last beat appears in the cycle in
// which busy falls.
// Each result beat is shown for one cycle and cannot be held off.
// Reset (synchronous) empties the graph; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_traversal_engine_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             func,
  input  logic [gte_pkg::VW-1:0] source_vertex,
  input  logic [gte_pkg::VW-1:0] target_vertex,
  input  logic [gte_pkg::VW-1:0] start_vertex,
  output logic                   strobe,
  output logic [1:0]             kind,
  output logic [gte_pkg::VW-1:0] vertex,
  output logic                   last
);
  import gte_pkg::*;

  rpt_t rpt;

  gte_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .func          (func_t'(func)),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .start_vertex  (start_vertex),
    .busy          (busy),
    .rpt           (rpt)
  );

  gte_result u_result (
    .clk    (clk),
    .rst    (rst),
    .rpt    (rpt),
    .strobe (strobe),
    .kind   (kind),
    .vertex (vertex),
    .last   (last)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_graph_traversal_engine_top.sv -----
// ----------------------------------------------------------------------------
// tb_graph_traversal_engine_top
// Self-checking testbench for the graph traversal engine.
//
// Commands go in one beat at a time over the start/busy handshake. Each one
// is fed to a behavioural copy of the graph store, which works out every
// status or visit beat that the command should produce. The result beats
// from the block are compared in order against that list. A short table of
// directed commands covers the edge cases. Random rounds follow, each
// building part of a graph and then walking it.
// ----------------------------------------------------------------------------

module tb_graph_traversal_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gte_pkg::*;

  localparam int PLAN_ROWS    = 25;
  localparam int RANDOM_ITEMS = 235;
  localparam int QUIET_FROM   = PLAN_ROWS + RANDOM_ITEMS - 40;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    func_t        op;
    logic [5:0]   src;
    logic [5:0]   dst;
    logic [5:0]   root;
  } cmd_t;

  typedef struct packed {
    kind_t        kind;
    logic [5:0]   vtx;
    logic         last;
  } beat_t;

  typedef struct packed {
    cmd_t         cmd;
    logic         typed;
    beat_t        beat;
  } row_t;

  localparam beat_t OK_BEAT  = '{KIND_ACCEPT, 6'd0, 1'b1};
  localparam beat_t REJ_BEAT = '{KIND_REJECT, 6'd0, 1'b1};
  localparam beat_t NO_BEAT  = '{KIND_ACCEPT, 6'd0, 1'b0};

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] func = FUNC_CLEAR;
  logic [5:0] source_vertex = '0;
  logic [5:0] target_vertex = '0;
  logic [5:0] start_vertex = '0;
  logic       strobe;
  logic [1:0] kind;
  logic [5:0] vertex;
  logic       last;

  graph_traversal_engine_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .source_vertex (source_vertex),
    .target_vertex (target_vertex),
    .start_vertex  (start_vertex),
    .strobe        (strobe),
    .kind          (kind),
    .vertex        (vertex),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Behavioural copy of the graph and the traversal scratch state.
  logic [5:0]  adj_nbr    [1:MAX_VERTICES][0:MAX_DEGREE-1];
  int unsigned out_degree [1:MAX_VERTICES];
  bit          seen       [1:MAX_VERTICES];
  int unsigned next_pos   [1:MAX_VERTICES];
  logic [5:0]  frontier   [0:MAX_VERTICES-1];
  int unsigned head;
  int unsigned tail;

  beat_t step_beats[$];
  beat_t expected_beats[$];
  int    mismatch_count = 0;
  int    items_issued = 0;
  longint cycle_count = 0;
  row_t  plan [0:PLAN_ROWS-1];

  function automatic void mark_visited(input logic [5:0] v);
    seen[v] = 1'b1;
    next_pos[v] = 0;
    if (tail < MAX_VERTICES) begin
      frontier[tail] = v;
      tail++;
    end
    step_beats.push_back(beat_t'{KIND_VISIT, v, 1'b0});
  endfunction

  function automatic void predict_graph_op(input cmd_t c);
    logic [5:0]  cur;
    logic [5:0]  w;
    int unsigned pos;
    step_beats.delete();
    case (c.op)
      FUNC_EDGE: begin
        if (c.src == 0 || c.src > MAX_VERTICES || c.dst == 0 || c.dst > MAX_VERTICES ||
            out_degree[c.src] >= MAX_DEGREE) begin
          step_beats.push_back(REJ_BEAT);
        end else begin
          adj_nbr[c.src][out_degree[c.src]] = c.dst;
          out_degree[c.src]++;
          step_beats.push_back(OK_BEAT);
        end
      end
      FUNC_CLEAR: begin
        for (int v = 1; v <= MAX_VERTICES; v++) out_degree[v] = 0;
        step_beats.push_back(OK_BEAT);
      end
      default: begin
        if (c.root == 0 || c.root > MAX_VERTICES) begin
          step_beats.push_back(REJ_BEAT);
        end else begin
          for (int v = 1; v <= MAX_VERTICES; v++) seen[v] = 1'b0;
          head = 0;
          tail = 0;
          mark_visited(c.root);
          if (c.op == FUNC_BFS) begin
            while (head < tail) begin
              cur = frontier[head];
              head++;
              for (int e = 0; e < out_degree[cur]; e++) begin
                w = adj_nbr[cur][e];
                if (!seen[w]) mark_visited(w);
              end
            end
          end else begin
            // The top of the stack resumes from where its list was left off.
            while (tail > 0) begin
              cur = frontier[tail-1];
              pos = next_pos[cur];
              if (pos < out_degree[cur]) begin
                w = adj_nbr[cur][pos];
                next_pos[cur] = pos + 1;
                if (!seen[w]) mark_visited(w);
              end else begin
                tail--;
              end
            end
          end
        end
      end
    endcase
    step_beats[step_beats.size()-1].last = 1'b1;
  endfunction

  // Drives one command beat, waits for it to be taken, then queues what it
  // should produce. A gap may follow before the next command.
  task automatic issue(input cmd_t c, input logic typed, input beat_t typed_beat);
    start         <= 1'b1;
    func          <= c.op;
    source_vertex <= c.src;
    target_vertex <= c.dst;
    start_vertex  <= c.root;
    do @(posedge clk); while (busy !== 1'b0);
    predict_graph_op(c);
    if (typed) begin
      expected_beats.push_back(typed_beat);
    end else begin
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    end
    items_issued++;
    if (items_issued < QUIET_FROM && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic random_round();
    cmd_t c;
    int   span;
    span = ($urandom_range(0, 4) == 0) ? MAX_VERTICES : $urandom_range(2, 8);
    if ($urandom_range(0, 2) == 0) begin
      c = '{FUNC_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
            6'($urandom_range(0, 63))};
      issue(c, 1'b0, NO_BEAT);
    end
    repeat ($urandom_range(2, 20)) begin
      c.op   = FUNC_EDGE;
      c.src  = 6'($urandom_range(1, span));
      c.dst  = 6'($urandom_range(1, span));
      c.root = 6'($urandom_range(0, 63));
      // Now and then a malformed edge, or one across the whole vertex range.
      case ($urandom_range(0, 11))
        0: c.src = 6'd0;
        1: c.dst = 6'd0;
        2: c.src = 6'($urandom_range(0, 63));
        3: c.dst = 6'($urandom_range(0, 63));
        default: ;
      endcase
      issue(c, 1'b0, NO_BEAT);
    end
    repeat ($urandom_range(1, 3)) begin
      c.op   = func_t'($urandom_range(FUNC_BFS, FUNC_DFS));
      c.src  = 6'($urandom_range(0, 63));
      c.dst  = 6'($urandom_range(0, 63));
      c.root = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, span));
      issue(c, 1'b0, NO_BEAT);
    end
  endtask

  initial begin
    for (int v = 1; v <= MAX_VERTICES; v++) begin
      out_degree[v] = 0;
      seen[v] = 1'b0;
      next_pos[v] = 0;
    end
    head = 0;
    tail = 0;

    plan = '{
      '{'{FUNC_BFS,   6'd0,  6'd0,  6'd5},  1'b1, '{KIND_VISIT, 6'd5, 1'b1}},
      '{'{FUNC_DFS,   6'd0,  6'd0,  6'd63}, 1'b1, '{KIND_VISIT, 6'd63, 1'b1}},
      '{'{FUNC_BFS,   6'd9,  6'd9,  6'd0},  1'b1, REJ_BEAT},
      '{'{FUNC_DFS,   6'd9,  6'd9,  6'd0},  1'b1, REJ_BEAT},
      '{'{FUNC_EDGE,  6'd0,  6'd5,  6'd0},  1'b1, REJ_BEAT},
      '{'{FUNC_EDGE,  6'd5,  6'd0,  6'd0},  1'b1, REJ_BEAT},
      '{'{FUNC_EDGE,  6'd63, 6'd1,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd63, 6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd2,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd3,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd4,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd5,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd6,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd7,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd1,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd1,  6'd9,  6'd0},  1'b1, REJ_BEAT},
      '{'{FUNC_EDGE,  6'd2,  6'd63, 6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_EDGE,  6'd63, 6'd63, 6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_BFS,   6'd0,  6'd0,  6'd1},  1'b0, NO_BEAT},
      '{'{FUNC_DFS,   6'd0,  6'd0,  6'd1},  1'b0, NO_BEAT},
      '{'{FUNC_DFS,   6'd0,  6'd0,  6'd63}, 1'b0, NO_BEAT},
      '{'{FUNC_CLEAR, 6'd0,  6'd0,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_BFS,   6'd0,  6'd0,  6'd1},  1'b1, '{KIND_VISIT, 6'd1, 1'b1}},
      '{'{FUNC_EDGE,  6'd1,  6'd2,  6'd0},  1'b1, OK_BEAT},
      '{'{FUNC_DFS,   6'd0,  6'd0,  6'd1},  1'b0, NO_BEAT}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) issue(plan[i].cmd, plan[i].typed, plan[i].beat);
    while (items_issued < PLAN_ROWS + RANDOM_ITEMS) random_round();

    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    beat_t want;
    if (!rst && strobe) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d vertex %0d last %0d", kind, vertex, last);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatch_count++;
        end
        if (vertex !== want.vtx) begin
          $error("vertex: expected %0d, got %0d", want.vtx, vertex);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
